/* hdl/hid_report_frame_assembler_unit_macros.svh */
// Assertion macros used by the report frame assembler controller.
`ifndef HID_REPORT_FRAME_ASSEMBLER_UNIT_MACROS_SVH
`define HID_REPORT_FRAME_ASSEMBLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HRFA_ASSERT_IMPL(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define HRFA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HRFA_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define HRFA_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

/* hdl/hrfa_pkg.sv */
// Shared constants and types of the report frame assembler.
`default_nettype none
package hrfa_pkg;
	localparam int unsigned LINE_CHARS = 63;
	localparam int unsigned STORE_WIDTH = 8;
	localparam int unsigned STORE_DEPTH = 512;
	localparam int unsigned STORE_AW = 9;

	localparam logic [2:0] CLS_IGNORE = 3'd0;
	localparam logic [2:0] CLS_CHUNK = 3'd1;
	localparam logic [2:0] CLS_FRAME_END = 3'd2;
	localparam logic [2:0] CLS_TEXT0 = 3'd3;
	localparam logic [2:0] CLS_TEXT1 = 3'd4;
	localparam logic [2:0] CLS_CLEAR = 3'd5;

	localparam logic [7:0] CMD_CHUNK0 = 8'h00;
	localparam logic [7:0] CMD_CHUNK_LIMIT = 8'h08;
	localparam logic [7:0] CMD_FRAME_END = 8'hFF;
	localparam logic [7:0] CMD_TEXT0 = 8'h01;
	localparam logic [7:0] CMD_TEXT1 = 8'h02;
	localparam logic [7:0] CMD_CLEAR = 8'h10;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_LINE_END = 2'd1;
	localparam logic [1:0] KIND_CANVAS = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [1:0] VIEW_WIDGETS = 2'd0;
	localparam logic [1:0] VIEW_TEXT = 2'd1;
	localparam logic [1:0] VIEW_CANVAS = 2'd2;

	localparam logic [2:0] SEL_CHAR = 3'd0;
	localparam logic [2:0] SEL_LINE_END = 3'd1;
	localparam logic [2:0] SEL_CLR_LINE_END = 3'd2;
	localparam logic [2:0] SEL_STATUS = 3'd3;
	localparam logic [2:0] SEL_CANVAS = 3'd4;

	typedef struct packed {
		logic clr;
		logic chr;
		logic lend;
		logic clr3;
		logic frame;
	} hrfa_plan_t;

	typedef struct packed {
		logic ready;
		logic take;
		logic sweep;
		logic rd_issue;
		logic load;
		logic [2:0] sel;
		logic line;
		logic last;
		logic [STORE_AW-1:0] addr;
		logic [5:0] word;
	} hrfa_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		hrfa_plan_t plan;
	} hrfa_stat_t;
endpackage
`default_nettype wire

/* hdl/hrfa_in_if.sv */
// Input channel carrying one report byte per item.
`default_nettype none
interface hrfa_in_if;
	logic valid;
	logic ready;
	logic [7:0] report_byte;
	logic first_of_report;
	logic end_of_report;
	modport source(output valid, report_byte, first_of_report, end_of_report, input ready);
	modport sink(input valid, report_byte, first_of_report, end_of_report, output ready);
endinterface
`default_nettype wire

/* hdl/hrfa_out_if.sv */
// Output channel carrying one result item.
`default_nettype none
interface hrfa_out_if;
	logic valid;
	logic ready;
	logic [1:0] result_kind;
	logic text_line;
	logic [5:0] position;
	logic [63:0] payload;
	logic [1:0] visible_view;
	logic last;
	modport source(output valid, result_kind, text_line, position, payload, visible_view, last,
		input ready);
	modport sink(input valid, result_kind, text_line, position, payload, visible_view, last,
		output ready);
endinterface
`default_nettype wire

/* hdl/hrfa_cfg_if.sv */
// Configuration write channel for the display enable register.
`default_nettype none
interface hrfa_cfg_if;
	logic valid;
	logic ready;
	logic display_enabled;
	modport source(output valid, display_enabled, input ready);
	modport sink(input valid, display_enabled, output ready);
endinterface
`default_nettype wire

/* hdl/hrfa_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module hrfa_ram #(
	parameter int unsigned WIDTH = hrfa_pkg::STORE_WIDTH,
	parameter int unsigned DEPTH = hrfa_pkg::STORE_DEPTH
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hdl/hrfa_ctrl.sv */
// Controller state machine sequencing clearing, results and frame conversion.
`default_nettype none
`include "hid_report_frame_assembler_unit_macros.svh"
module hrfa_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire hrfa_pkg::hrfa_stat_t stat,
	output hrfa_pkg::hrfa_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_CHAR = 3'd2;
	localparam logic [2:0] S_LEND = 3'd3;
	localparam logic [2:0] S_CLR3 = 3'd4;
	localparam logic [2:0] S_CREAD = 3'd5;
	localparam logic [2:0] S_CEMIT = 3'd6;

	logic [2:0] state_q, state_n;
	logic [8:0] cnt_q, cnt_n;
	logic [5:0] word_q, word_n;
	logic pend_chr_q, pend_lend_q, pend_clr3_q, pend_frame_q;
	logic pend_chr_n, pend_lend_n, pend_clr3_n, pend_frame_n;

	function automatic logic [2:0] pick(input logic chr, input logic lend,
		input logic clr3, input logic frame);
		logic [2:0] s;
		if (chr) s = S_CHAR;
		else if (lend) s = S_LEND;
		else if (clr3) s = S_CLR3;
		else if (frame) s = S_CREAD;
		else s = S_IDLE;
		return s;
	endfunction

	always_comb begin
		cmd = '0;
		state_n = state_q;
		cnt_n = cnt_q;
		word_n = word_q;
		pend_chr_n = pend_chr_q;
		pend_lend_n = pend_lend_q;
		pend_clr3_n = pend_clr3_q;
		pend_frame_n = pend_frame_q;
		cmd.word = word_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				cmd.take = stat.in_valid;
				if (stat.in_valid) begin
					pend_chr_n = stat.plan.chr;
					pend_lend_n = stat.plan.lend;
					pend_clr3_n = stat.plan.clr3;
					pend_frame_n = stat.plan.frame;
					word_n = '0;
					cnt_n = '0;
					state_n = stat.plan.clr ? S_SWEEP : pick(stat.plan.chr, stat.plan.lend,
						stat.plan.clr3, stat.plan.frame);
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				cmd.addr = cnt_q;
				cnt_n = cnt_q + 9'd1;
				if (cnt_q == 9'd511) begin
					cnt_n = '0;
					state_n = pick(pend_chr_q, pend_lend_q, pend_clr3_q, pend_frame_q);
				end
			end
			S_CHAR: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.sel = hrfa_pkg::SEL_CHAR;
					cmd.last = !pend_lend_q;
					pend_chr_n = 1'b0;
					state_n = pick(1'b0, pend_lend_q, pend_clr3_q, pend_frame_q);
				end
			end
			S_LEND: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.sel = hrfa_pkg::SEL_LINE_END;
					cmd.last = 1'b1;
					pend_lend_n = 1'b0;
					state_n = pick(1'b0, 1'b0, pend_clr3_q, pend_frame_q);
				end
			end
			S_CLR3: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.sel = (cnt_q == 9'd2) ? hrfa_pkg::SEL_STATUS : hrfa_pkg::SEL_CLR_LINE_END;
					cmd.line = cnt_q[0];
					cmd.last = (cnt_q == 9'd2);
					cnt_n = cnt_q + 9'd1;
					if (cnt_q == 9'd2) begin
						cnt_n = '0;
						pend_clr3_n = 1'b0;
						state_n = pick(1'b0, 1'b0, 1'b0, pend_frame_q);
					end
				end
			end
			S_CREAD: begin
				cmd.addr = {word_q[5:4], cnt_q[6:0]};
				cmd.rd_issue = !cnt_q[7];
				cnt_n = cnt_q + 9'd1;
				if (cnt_q[7]) begin
					cnt_n = '0;
					state_n = S_CEMIT;
				end
			end
			S_CEMIT: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.sel = hrfa_pkg::SEL_CANVAS;
					cmd.last = (word_q == 6'd63);
					word_n = word_q + 6'd1;
					if (word_q[3:0] == 4'd15) begin
						if (word_q == 6'd63) begin
							pend_frame_n = 1'b0;
							state_n = S_IDLE;
						end else begin
							state_n = S_CREAD;
						end
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			cnt_q <= '0;
			word_q <= '0;
			pend_chr_q <= 1'b0;
			pend_lend_q <= 1'b0;
			pend_clr3_q <= 1'b0;
			pend_frame_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q <= cnt_n;
			word_q <= word_n;
			pend_chr_q <= pend_chr_n;
			pend_lend_q <= pend_lend_n;
			pend_clr3_q <= pend_clr3_n;
			pend_frame_q <= pend_frame_n;
		end
	end

	`HRFA_ASSERT_IMPL(a_load_needs_room, clk, arst_n, cmd.load, stat.out_free)
	`HRFA_ASSERT_IMPL(a_take_only_idle, clk, arst_n, cmd.take, state_q == S_IDLE)
	`HRFA_ASSERT_NEXT(a_sweep_ends, clk, arst_n, state_q == S_SWEEP && cnt_q == 9'd511,
		state_q != S_SWEEP)
	`HRFA_ASSERT_NEXT(a_frame_done, clk, arst_n, state_q == S_CEMIT && cmd.load && word_q == 6'd63,
		state_q == S_IDLE)
endmodule
`default_nettype wire

/* hdl/hrfa_datapath.sv */
// Datapath holding the report state, the pixel store, the row buffer and the output register.
`default_nettype none
module hrfa_datapath (
	input wire logic clk,
	input wire logic arst_n,
	hrfa_in_if.sink rin,
	hrfa_out_if.source rout,
	hrfa_cfg_if.sink cfg,
	input wire hrfa_pkg::hrfa_cmd_t cmd,
	output hrfa_pkg::hrfa_stat_t stat
);
	logic en_q, in_frame_q, text_flag_q, canvas_flag_q;
	logic [2:0] class_q, chunk_q;
	logic [6:0] bpos_q;
	logic [1:0] view_q;
	logic in_frame_n, text_flag_n, canvas_flag_n;
	logic [2:0] class_n, chunk_n;
	logic [6:0] bpos_n;
	logic [1:0] view_n;
	hrfa_pkg::hrfa_plan_t plan;
	logic wr_en;
	logic [hrfa_pkg::STORE_AW-1:0] wr_addr;
	logic [7:0] char_q;
	logic [5:0] char_pos_q, char_pos_n, len_q, len_n;
	logic line_q, line_n;
	logic rd_valid_s1;
	logic [7:0] rd_data;
	logic [127:0] row_q [8];
	logic out_valid_q;
	logic [1:0] kind_q;
	logic oline_q;
	logic [5:0] opos_q;
	logic [63:0] opay_q;
	logic [1:0] oview_q;
	logic olast_q;

	always_comb begin
		in_frame_n = in_frame_q;
		text_flag_n = text_flag_q;
		canvas_flag_n = canvas_flag_q;
		class_n = class_q;
		chunk_n = chunk_q;
		bpos_n = bpos_q;
		view_n = view_q;
		plan = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		char_pos_n = char_pos_q;
		len_n = len_q;
		line_n = line_q;
		if (!en_q) begin
			class_n = hrfa_pkg::CLS_IGNORE;
			bpos_n = '0;
		end else if (rin.first_of_report) begin
			bpos_n = '0;
			if (rin.report_byte == hrfa_pkg::CMD_CHUNK0 && !in_frame_q) begin
				in_frame_n = 1'b1;
				class_n = hrfa_pkg::CLS_CHUNK;
				chunk_n = '0;
			end else if (in_frame_q && rin.report_byte < hrfa_pkg::CMD_CHUNK_LIMIT) begin
				class_n = hrfa_pkg::CLS_CHUNK;
				chunk_n = rin.report_byte[2:0];
			end else if (rin.report_byte == hrfa_pkg::CMD_FRAME_END && in_frame_q) begin
				in_frame_n = 1'b0;
				class_n = hrfa_pkg::CLS_FRAME_END;
			end else if (rin.report_byte == hrfa_pkg::CMD_TEXT0) begin
				in_frame_n = 1'b0;
				class_n = hrfa_pkg::CLS_TEXT0;
			end else if (rin.report_byte == hrfa_pkg::CMD_TEXT1) begin
				in_frame_n = 1'b0;
				class_n = hrfa_pkg::CLS_TEXT1;
			end else if (rin.report_byte == hrfa_pkg::CMD_CLEAR) begin
				in_frame_n = 1'b0;
				class_n = hrfa_pkg::CLS_CLEAR;
				plan.clr = 1'b1;
			end else begin
				class_n = hrfa_pkg::CLS_IGNORE;
			end
		end else if (class_q != hrfa_pkg::CLS_IGNORE) begin
			bpos_n = (bpos_q < 7'd127) ? bpos_q + 7'd1 : bpos_q;
			case (class_q) inside
				hrfa_pkg::CLS_CHUNK: begin
					if (bpos_n <= 7'd63) begin
						wr_en = 1'b1;
						wr_addr = {chunk_q, bpos_n[5:0]};
					end
				end
				hrfa_pkg::CLS_FRAME_END: begin
					if (bpos_n >= 7'd1 && bpos_n <= 7'd8) begin
						wr_en = 1'b1;
						wr_addr = {3'(bpos_n - 7'd1), 6'd0};
					end
				end
				hrfa_pkg::CLS_TEXT0, hrfa_pkg::CLS_TEXT1: begin
					if (bpos_n <= 7'(hrfa_pkg::LINE_CHARS)) begin
						plan.chr = 1'b1;
						char_pos_n = 6'(bpos_n - 7'd1);
						line_n = (class_q == hrfa_pkg::CLS_TEXT1);
					end
				end
				default: begin
				end
			endcase
		end
		if (en_q && rin.end_of_report && class_n != hrfa_pkg::CLS_IGNORE) begin
			case (class_n) inside
				hrfa_pkg::CLS_FRAME_END: begin
					plan.frame = 1'b1;
					if (!canvas_flag_q) begin
						canvas_flag_n = 1'b1;
						text_flag_n = 1'b0;
						view_n = hrfa_pkg::VIEW_CANVAS;
					end
				end
				hrfa_pkg::CLS_TEXT0, hrfa_pkg::CLS_TEXT1: begin
					plan.lend = 1'b1;
					line_n = (class_n == hrfa_pkg::CLS_TEXT1);
					len_n = (bpos_n > 7'(hrfa_pkg::LINE_CHARS)) ?
						6'(hrfa_pkg::LINE_CHARS) : bpos_n[5:0];
					if (!text_flag_q) begin
						text_flag_n = 1'b1;
						view_n = hrfa_pkg::VIEW_TEXT;
					end
				end
				hrfa_pkg::CLS_CLEAR: begin
					plan.clr3 = 1'b1;
					if (canvas_flag_q) begin
						canvas_flag_n = 1'b0;
						view_n = hrfa_pkg::VIEW_WIDGETS;
					end else if (text_flag_q) begin
						text_flag_n = 1'b0;
						view_n = hrfa_pkg::VIEW_WIDGETS;
					end
				end
				default: begin
				end
			endcase
			class_n = hrfa_pkg::CLS_IGNORE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			in_frame_q <= 1'b0;
			class_q <= hrfa_pkg::CLS_IGNORE;
			chunk_q <= '0;
			bpos_q <= '0;
			text_flag_q <= 1'b0;
			canvas_flag_q <= 1'b0;
			view_q <= hrfa_pkg::VIEW_WIDGETS;
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cfg.valid) begin
				en_q <= cfg.display_enabled;
			end
			if (cmd.take) begin
				in_frame_q <= in_frame_n;
				class_q <= class_n;
				chunk_q <= chunk_n;
				bpos_q <= bpos_n;
				text_flag_q <= text_flag_n;
				canvas_flag_q <= canvas_flag_n;
				view_q <= view_n;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (rout.ready) begin
				out_valid_q <= 1'b0;
			end
			rd_valid_s1 <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			char_q <= rin.report_byte;
			char_pos_q <= char_pos_n;
			len_q <= len_n;
			line_q <= line_n;
		end
		if (rd_valid_s1) begin
			for (int b = 0; b < 8; b++) begin
				row_q[b] <= {row_q[b][126:0], rd_data[b]};
			end
		end
		if (cmd.load) begin
			olast_q <= cmd.last;
			oview_q <= view_q;
			case (cmd.sel)
				hrfa_pkg::SEL_CHAR: begin
					kind_q <= hrfa_pkg::KIND_CHAR;
					oline_q <= line_q;
					opos_q <= char_pos_q;
					opay_q <= {56'd0, char_q};
				end
				hrfa_pkg::SEL_LINE_END: begin
					kind_q <= hrfa_pkg::KIND_LINE_END;
					oline_q <= line_q;
					opos_q <= len_q;
					opay_q <= '0;
				end
				hrfa_pkg::SEL_CLR_LINE_END: begin
					kind_q <= hrfa_pkg::KIND_LINE_END;
					oline_q <= cmd.line;
					opos_q <= '0;
					opay_q <= '0;
				end
				hrfa_pkg::SEL_CANVAS: begin
					kind_q <= hrfa_pkg::KIND_CANVAS;
					oline_q <= 1'b0;
					opos_q <= cmd.word;
					opay_q <= cmd.word[0] ? row_q[cmd.word[3:1]][63:0] :
						row_q[cmd.word[3:1]][127:64];
				end
				default: begin
					kind_q <= hrfa_pkg::KIND_STATUS;
					oline_q <= 1'b0;
					opos_q <= '0;
					opay_q <= '0;
				end
			endcase
		end
	end

	hrfa_ram #(
		.WIDTH(hrfa_pkg::STORE_WIDTH),
		.DEPTH(hrfa_pkg::STORE_DEPTH)
	) u_store (
		.clk(clk),
		.we(cmd.sweep | (cmd.take & wr_en)),
		.waddr(cmd.sweep ? cmd.addr : wr_addr),
		.wdata(cmd.sweep ? 8'd0 : rin.report_byte),
		.raddr(cmd.addr),
		.rdata(rd_data)
	);

	assign rin.ready = cmd.ready;
	assign cfg.ready = 1'b1;
	assign rout.valid = out_valid_q;
	assign rout.result_kind = kind_q;
	assign rout.text_line = oline_q;
	assign rout.position = opos_q;
	assign rout.payload = opay_q;
	assign rout.visible_view = oview_q;
	assign rout.last = olast_q;
	assign stat.in_valid = rin.valid;
	assign stat.out_free = !out_valid_q || rout.ready;
	assign stat.plan = plan;
endmodule
`default_nettype wire

/* hdl/hid_report_frame_assembler_unit.sv */
// Top level of the report frame assembler: controller, datapath and pixel store.
// A byte that yields no result leaves the controller idle; a char and a line end each emit one result.
// A frame end runs four passes, each of 128 store reads into the row buffer and then 16 canvas words.
// A clear command runs a pass over all 512 bytes of the pixel store, one byte per cycle, without input.
// After reset the same clearing pass runs before the first item is accepted.
// Results wait in an output register; output stalls hold the sequencer in place.
`default_nettype none
module hid_report_frame_assembler_unit (
	input wire logic clk,
	input wire logic arst_n,
	hrfa_in_if.sink report_in,
	hrfa_out_if.source result_out,
	hrfa_cfg_if.sink cfg
);
	hrfa_pkg::hrfa_cmd_t cmd;
	hrfa_pkg::hrfa_stat_t stat;

	hrfa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.cmd(cmd)
	);

	hrfa_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.rin(report_in),
		.rout(result_out),
		.cfg(cfg),
		.cmd(cmd),
		.stat(stat)
	);
endmodule
`default_nettype wire

/* tb/sv/hid_report_frame_assembler_unit_test.sv */
// Self-checking testbench for the report frame assembler: predicts every result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module hid_report_frame_assembler_unit_test;
	import hrfa_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic line;
		logic [5:0] pos;
		logic [63:0] data;
		logic [1:0] view;
		logic last;
	} frame_result_t;

	class frame_scoreboard;
		logic [7:0] pix [512];
		logic framing;
		logic [2:0] rclass;
		logic [2:0] chunk;
		logic [6:0] bpos;
		logic text_on;
		logic canvas_on;
		logic [1:0] view;
		logic enabled;
		frame_result_t pending [$];
		int errors;
		int checked;

		function void clear_state();
			foreach (pix[i]) pix[i] = 8'h00;
			framing = 0;
			rclass = CLS_IGNORE;
			chunk = 0;
			bpos = 0;
			text_on = 0;
			canvas_on = 0;
			view = VIEW_WIDGETS;
			enabled = 1;
			pending.delete();
			errors = 0;
			checked = 0;
		endfunction

		function logic [63:0] canvas_row(int w);
			logic [63:0] acc;
			int row;
			int half;
			row = w >> 1;
			half = w & 1;
			acc = 0;
			for (int c = 0; c < 64; c++) begin
				acc = {acc[62:0], pix[((row >> 3) * 128 + half * 64 + c) & 511][row & 7]};
			end
			return acc;
		endfunction

		function void decode_command(logic [7:0] cmd);
			if (cmd == CMD_CHUNK0 && !framing) begin
				framing = 1;
				rclass = CLS_CHUNK;
				chunk = 0;
			end else if (framing && cmd < CMD_CHUNK_LIMIT) begin
				rclass = CLS_CHUNK;
				chunk = cmd[2:0];
			end else if (cmd == CMD_FRAME_END && framing) begin
				framing = 0;
				rclass = CLS_FRAME_END;
			end else if (cmd == CMD_TEXT0) begin
				framing = 0;
				rclass = CLS_TEXT0;
			end else if (cmd == CMD_TEXT1) begin
				framing = 0;
				rclass = CLS_TEXT1;
			end else if (cmd == CMD_CLEAR) begin
				framing = 0;
				foreach (pix[i]) pix[i] = 8'h00;
				rclass = CLS_CLEAR;
			end else begin
				rclass = CLS_IGNORE;
			end
		endfunction

		function void note_byte(logic [7:0] b, logic first, logic fin);
			frame_result_t r [$];
			frame_result_t e;
			logic tl;
			if (!enabled) begin
				rclass = CLS_IGNORE;
				bpos = 0;
				return;
			end
			tl = (rclass == CLS_TEXT1);
			if (first) begin
				bpos = 0;
				decode_command(b);
				tl = (rclass == CLS_TEXT1);
			end else begin
				if (rclass == CLS_IGNORE) return;
				if (bpos < 127) bpos++;
				if (rclass == CLS_CHUNK) begin
					if (bpos <= 63) pix[(chunk * 64 + bpos) & 511] = b;
				end else if (rclass == CLS_FRAME_END) begin
					if (bpos >= 1 && bpos <= 8) pix[((bpos - 1) * 64) & 511] = b;
				end else if (rclass == CLS_TEXT0 || rclass == CLS_TEXT1) begin
					if (bpos <= LINE_CHARS) begin
						e = '0;
						e.kind = KIND_CHAR;
						e.line = tl;
						e.pos = 6'(bpos - 1);
						e.data = {56'd0, b};
						r.push_back(e);
					end
				end
			end
			if (fin && rclass != CLS_IGNORE) begin
				if (rclass == CLS_FRAME_END) begin
					for (int w = 0; w < 64; w++) begin
						e = '0;
						e.kind = KIND_CANVAS;
						e.pos = 6'(w);
						e.data = canvas_row(w);
						r.push_back(e);
					end
					if (!canvas_on) begin
						canvas_on = 1;
						text_on = 0;
						view = VIEW_CANVAS;
					end
				end else if (rclass == CLS_TEXT0 || rclass == CLS_TEXT1) begin
					if (!text_on) begin
						text_on = 1;
						view = VIEW_TEXT;
					end
					e = '0;
					e.kind = KIND_LINE_END;
					e.line = tl;
					e.pos = (bpos > LINE_CHARS) ? 6'(LINE_CHARS) : 6'(bpos);
					r.push_back(e);
				end else if (rclass == CLS_CLEAR) begin
					if (canvas_on) begin
						canvas_on = 0;
						view = VIEW_WIDGETS;
					end else if (text_on) begin
						text_on = 0;
						view = VIEW_WIDGETS;
					end
					e = '0;
					e.kind = KIND_LINE_END;
					r.push_back(e);
					e.line = 1;
					r.push_back(e);
					e.line = 0;
					e.kind = KIND_STATUS;
					r.push_back(e);
				end
				rclass = CLS_IGNORE;
			end
			foreach (r[k]) begin
				r[k].view = view;
				r[k].last = (k == r.size() - 1);
				pending.push_back(r[k]);
			end
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (pending.size() == 0) begin
				$display("%t: unexpected result, expected none, actual %h", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.kind !== want.kind)
				$display("%t: kind expected %0d actual %0d", $realtime, want.kind, got.kind);
			if (got.line !== want.line)
				$display("%t: line expected %0d actual %0d", $realtime, want.line, got.line);
			if (got.pos !== want.pos)
				$display("%t: position expected %0d actual %0d", $realtime, want.pos, got.pos);
			if (got.data !== want.data)
				$display("%t: payload expected %h actual %h", $realtime, want.data, got.data);
			if (got.view !== want.view)
				$display("%t: view expected %0d actual %0d", $realtime, want.view, got.view);
			if (got.last !== want.last)
				$display("%t: last expected %0d actual %0d", $realtime, want.last, got.last);
			if (got !== want) errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	hrfa_in_if report_in ();
	hrfa_out_if result_out ();
	hrfa_cfg_if cfg ();
	frame_scoreboard board;
	int burst_left;
	int sent;
	int stall_mode;

	hid_report_frame_assembler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.report_in(report_in.sink),
		.result_out(result_out.source),
		.cfg(cfg.sink)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#200ms;
		$display("hid_report_frame_assembler_unit_test NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_out.valid && result_out.ready)
			board.check_result({result_out.result_kind, result_out.text_line, result_out.position,
				result_out.payload, result_out.visible_view, result_out.last});
		case (stall_mode)
			0: result_out.ready <= 1'b1;
			1: result_out.ready <= ($urandom_range(0, 3) != 0);
			default: result_out.ready <= ($urandom_range(0, 2) == 0);
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic first, input logic fin);
		if (burst_left == 0) begin
			report_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		report_in.valid <= 1'b1;
		report_in.report_byte <= b;
		report_in.first_of_report <= first;
		report_in.end_of_report <= fin;
		do @(posedge clk); while (!report_in.ready);
		board.note_byte(b, first, fin);
		sent++;
	endtask

	task automatic send_report(input logic [7:0] cmd, input int len, input logic cut);
		send_byte(cmd, 1'b1, len == 0 && !cut);
		for (int i = 1; i <= len; i++)
			send_byte(8'($urandom), 1'b0, i == len && !cut);
	endtask

	task automatic drain();
		report_in.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_enable(input logic en);
		drain();
		cfg.valid <= 1'b1;
		cfg.display_enabled <= en;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		board.enabled = en;
	endtask

	task automatic random_report();
		int pick;
		int n;
		logic [7:0] cmd;
		pick = $urandom_range(0, 99);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 9);
		if (pick < 35) cmd = 8'($urandom_range(0, 7));
		else if (pick < 45) cmd = CMD_FRAME_END;
		else if (pick < 65) cmd = CMD_TEXT0;
		else if (pick < 80) cmd = CMD_TEXT1;
		else if (pick < 84) cmd = CMD_CLEAR;
		else cmd = 8'($urandom);
		if (pick >= 92) send_byte(8'($urandom), 1'b0, $urandom_range(0, 1));
		else send_report(cmd, n, $urandom_range(0, 9) == 0);
	endtask

	initial begin
		board = new();
		board.clear_state();
		burst_left = 0;
		sent = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		report_in.valid = 1'b0;
		report_in.report_byte = 8'h00;
		report_in.first_of_report = 1'b0;
		report_in.end_of_report = 1'b0;
		result_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.display_enabled = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_report(CMD_TEXT0, 2, 1'b0);
		send_byte(8'hAB, 1'b0, 1'b1);
		send_report(CMD_CHUNK0, 3, 1'b0);
		send_byte(8'h03, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		send_report(CMD_FRAME_END, 8, 1'b0);
		send_report(CMD_TEXT1, 0, 1'b0);
		send_report(CMD_TEXT0, 1, 1'b1);
		send_report(CMD_CLEAR, 0, 1'b0);
		send_report(8'h80, 1, 1'b0);
		send_report(CMD_TEXT1, 66, 1'b0);
		send_report(CMD_CLEAR, 0, 1'b0);

		write_enable(1'b0);
		send_report(CMD_TEXT0, 3, 1'b0);
		write_enable(1'b1);
		send_byte(8'h41, 1'b0, 1'b1);

		for (int i = 0; sent < 265; i++) begin
			if (i % 12 == 0) stall_mode = $urandom_range(0, 2);
			if (i == 20) drain();
			if (i % 30 == 29) begin
				write_enable(1'b0);
				send_report(CMD_TEXT1, 2, 1'b0);
				write_enable(1'b1);
			end
			random_report();
		end
		stall_mode = 1;
		drain();
		$display("Sent %0d report bytes and checked %0d results over text, canvas, clear and",
			sent, board.checked);
		$display("disable phases with random gaps and output stalls.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("hid_report_frame_assembler_unit_test OK");
		else
			$display("hid_report_frame_assembler_unit_test NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

/* hid_report_frame_assembler_unit.f */
+incdir+hdl
hdl/hrfa_pkg.sv
hdl/hrfa_in_if.sv
hdl/hrfa_out_if.sv
hdl/hrfa_cfg_if.sv
hdl/hrfa_ram.sv
hdl/hrfa_ctrl.sv
hdl/hrfa_datapath.sv
hdl/hid_report_frame_assembler_unit.sv
tb/sv/hid_report_frame_assembler_unit_test.sv
